@@ hdl/sfla_pkg.sv @@
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int ADDR_W    = 32;
    localparam int STRIDE_W  = 13;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 3;
    localparam int FILL_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd256;

    localparam logic ENTRY_TAKEN = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_EXHAUSTED    = 3'd1,
        ST_MISALIGNED   = 3'd2,
        ST_NOT_ALLOC    = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } t_status;

    typedef enum logic [FILL_W-1:0] {
        FILL_EMPTY   = 2'd0,
        FILL_PARTIAL = 2'd1,
        FILL_FULL    = 2'd2
    } t_fill;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE       = 2'd0,
        CFG_STRIDE     = 2'd1,
        CFG_SLOT_COUNT = 2'd2
    } t_cfg_idx;

endpackage

@@ hdl/slab_free_list_allocator.sv @@
`timescale 1ns / 1ps
// Allocate: S_ARD, S_AOUT, then o_done, next word taken in S_IDLE; exhausted from S_IDLE.
// Free: the divider turns the offset into a slot index one quotient bit per cycle, and
//   misaligned or out-of-range offsets end there; else S_FRD checks and frees the entry.
// Reset (i_rst_n low, synchronous) is followed by a pass that chains the link memory,
//   one entry a cycle, with busy high; config writes are taken meanwhile.
// Each result comes with o_done high for a single cycle; the receiver cannot stall.

module slab_free_list_allocator #(
    parameter int SLOTS = sfla_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_op,
    input  logic [sfla_pkg::ADDR_W-1:0]     i_address,
    input  logic                            i_cfg_we,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfla_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                            o_done,
    output logic [sfla_pkg::STATUS_W-1:0]   o_status,
    output logic [sfla_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [sfla_pkg::COUNT_W-1:0]    o_used_slots,
    output logic [sfla_pkg::FILL_W-1:0]     o_fill_state
);

    localparam int AW  = sfla_pkg::ADDR_W;
    localparam int SW  = sfla_pkg::STRIDE_W;
    localparam int KW  = sfla_pkg::COUNT_W;
    localparam int IW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int WW  = (CW > KW) ? CW : KW;
    localparam int PW  = IW + SW;

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_ARD  = 6'b000100,
        S_AOUT = 6'b001000,
        S_DIV  = 6'b010000,
        S_FRD  = 6'b100000
    } t_state;

    typedef struct packed {
        logic          taken;
        logic [IW-1:0] link;
    } t_entry;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_init_idx, n_init_idx;
    logic [IW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_used, n_used;
    logic [IW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_prod, n_prod;

    logic [AW-1:0]   r_base;
    logic [SW-1:0]   r_stride;
    logic [KW-1:0]   r_slot_count;

    t_entry          r_mem [SLOTS];
    t_entry          r_rd_data;
    logic [IW-1:0]   w_rd_addr;
    logic            w_we;
    logic [IW-1:0]   w_wr_addr;
    t_entry          w_wr_data;

    logic            r_done, n_done;
    logic [sfla_pkg::STATUS_W-1:0] r_status, n_status;
    logic [AW-1:0]   r_granted, n_granted;
    logic [KW-1:0]   r_used_out;
    logic [sfla_pkg::FILL_W-1:0]   r_fill;

    logic [SW-1:0]   w_stride;
    logic [WW-1:0]   w_cnt_wide;
    logic [CW-1:0]   w_count;
    logic [WW-1:0]   w_used_wide;
    logic [PW-1:0]   w_prod;
    logic            w_exhausted;
    logic            w_div_start;
    logic            w_div_done;
    logic [AW-1:0]   w_quo;
    logic [SW-1:0]   w_rem;
    logic [sfla_pkg::FILL_W-1:0]   w_fill;

    always_comb begin
        w_stride    = (r_stride == '0) ? SW'(1) : r_stride;
        w_cnt_wide  = WW'(r_slot_count);
        w_count     = (w_cnt_wide > WW'(SLOTS)) ? CW'(SLOTS) : CW'(w_cnt_wide);
        w_exhausted = (r_used >= w_count) || (CW'(r_head) >= w_count);
        w_prod      = r_head * w_stride;
    end

    sfla_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_address - r_base),
        .i_divisor   (w_stride),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_init_idx  = r_init_idx;
        n_head      = r_head;
        n_used      = r_used;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_done      = 1'b0;
        n_status    = sfla_pkg::ST_OK;
        n_granted   = '0;
        w_div_start = 1'b0;
        w_rd_addr   = r_head;
        w_we        = 1'b0;
        w_wr_addr   = r_idx;
        w_wr_data   = '{taken: ~sfla_pkg::ENTRY_TAKEN, link: r_head};

        case (r_state)
            S_INIT: begin
                w_we      = 1'b1;
                w_wr_addr = r_init_idx;
                w_wr_data = '{taken: ~sfla_pkg::ENTRY_TAKEN,
                              link: (r_init_idx == IW'(SLOTS - 1)) ? '0
                                    : r_init_idx + IW'(1)};
                n_init_idx = r_init_idx + IW'(1);
                if (r_init_idx == IW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_op == sfla_pkg::OP_FREE) begin
                        w_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else if (w_exhausted) begin
                        n_done   = 1'b1;
                        n_status = sfla_pkg::ST_EXHAUSTED;
                    end else begin
                        n_state = S_ARD;
                    end
                end
            end
            S_ARD: begin
                w_we      = 1'b1;
                w_wr_addr = r_head;
                w_wr_data = '{taken: sfla_pkg::ENTRY_TAKEN, link: '0};
                n_head    = r_rd_data.link;
                n_used    = r_used + CW'(1);
                n_prod    = AW'(w_prod);
                n_state   = S_AOUT;
            end
            S_AOUT: begin
                n_done    = 1'b1;
                n_granted = r_base + r_prod;
                n_state   = S_IDLE;
            end
            S_DIV: begin
                w_rd_addr = w_quo[IW-1:0];
                if (w_div_done) begin
                    if (w_rem != '0) begin
                        n_done   = 1'b1;
                        n_status = sfla_pkg::ST_MISALIGNED;
                        n_state  = S_IDLE;
                    end else if (w_quo >= AW'(w_count)) begin
                        n_done   = 1'b1;
                        n_status = sfla_pkg::ST_OUT_OF_RANGE;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = w_quo[IW-1:0];
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_rd_data.taken != sfla_pkg::ENTRY_TAKEN) begin
                    n_status = sfla_pkg::ST_NOT_ALLOC;
                end else begin
                    w_we   = 1'b1;
                    n_head = r_idx;
                    if (r_used != '0) begin
                        n_used = r_used - CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_used_wide = WW'(n_used);
        if (n_used == '0) begin
            w_fill = sfla_pkg::FILL_EMPTY;
        end else if (n_used >= w_count) begin
            w_fill = sfla_pkg::FILL_FULL;
        end else begin
            w_fill = sfla_pkg::FILL_PARTIAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_idx   <= '0;
            r_head       <= '0;
            r_used       <= '0;
            r_done       <= 1'b0;
            r_base       <= sfla_pkg::BASE_RST;
            r_stride     <= sfla_pkg::STRIDE_RST;
            r_slot_count <= sfla_pkg::COUNT_RST;
        end else begin
            r_state    <= n_state;
            r_init_idx <= n_init_idx;
            r_head     <= n_head;
            r_used     <= n_used;
            r_done     <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfla_pkg::CFG_BASE:       r_base       <= i_cfg_data[AW-1:0];
                    sfla_pkg::CFG_STRIDE:     r_stride     <= i_cfg_data[SW-1:0];
                    sfla_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[KW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_prod <= n_prod;
        if (n_done) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_used_out <= w_used_wide[KW-1:0];
            r_fill     <= w_fill;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_used_slots      = r_used_out;
    assign o_fill_state      = r_fill;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOTS))
        else $error("used count beyond slot total");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ARD |=> r_used == $past(r_used) + CW'(1))
        else $error("allocate did not bump used count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_status != sfla_pkg::ST_OK |-> r_granted == '0)
        else $error("rejected word carries an address");

    a_free_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FRD |-> $past(r_state) == S_DIV)
        else $error("free lookup without division");

endmodule

@@ hdl/sfla_div.sv @@
`timescale 1ns / 1ps

module sfla_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sfla_pkg::ADDR_W-1:0]    i_dividend,
    input  logic [sfla_pkg::STRIDE_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [sfla_pkg::ADDR_W-1:0]    o_quotient,
    output logic [sfla_pkg::STRIDE_W-1:0]  o_remainder
);

    localparam int DW   = sfla_pkg::ADDR_W;
    localparam int VW   = sfla_pkg::STRIDE_W;
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;

    logic [VW:0]     w_trial;
    logic            w_fits;
    logic [VW:0]     w_rem_next;

    // restoring, one quotient bit per cycle
    always_comb begin
        w_trial    = {r_rem, r_quo[DW-1]};
        w_fits     = (w_trial >= {1'b0, r_div});
        w_rem_next = w_fits ? (w_trial - {1'b0, r_div}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_fits};
            r_rem <= w_rem_next[VW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_div_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !r_busy |=> r_busy && r_cnt == CNTW'(DW))
        else $error("divider did not load");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == CNTW'(1) |=> r_done && !r_busy)
        else $error("divider did not finish");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_div == '0) || (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule
